### hw/rtl/sciot_pkg.sv
// ----------------------------------------------------------------------------
// sciot_pkg
// Types, codes and constants for the sound co-processor I/O page and timers.
// ----------------------------------------------------------------------------
package sciot_pkg;

    localparam int SLOW_PRESCALE  = 128;
    localparam int FAST_PRESCALE  = 16;
    localparam int BOOT_ROM_BYTES = 64;
    localparam int NUM_TIMERS     = 3;
    localparam int NUM_IN_LATCH   = 6;
    localparam int NUM_OUT_LATCH  = 4;

    // Prescaler holds ticks left minus one, so reload with period minus one.
    localparam logic [7:0] SLOW_RELOAD = 8'(SLOW_PRESCALE - 1);
    localparam logic [7:0] FAST_RELOAD = 8'(FAST_PRESCALE - 1);

    // Action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_CPU_RD  = 3'd1;
    localparam logic [2:0] ACT_CPU_WR  = 3'd2;
    localparam logic [2:0] ACT_HOST_WR = 3'd3;
    localparam logic [2:0] ACT_HOST_RD = 3'd4;

    // Route codes
    localparam logic [2:0] ROUTE_NONE  = 3'd0;
    localparam logic [2:0] ROUTE_LOCAL = 3'd1;
    localparam logic [2:0] ROUTE_ROM   = 3'd2;
    localparam logic [2:0] ROUTE_RAM   = 3'd3;
    localparam logic [2:0] ROUTE_DSP   = 3'd4;

    // Register offsets within the 0xf0-0xff page
    localparam logic [3:0] REG_TEST     = 4'h0;
    localparam logic [3:0] REG_CONTROL  = 4'h1;
    localparam logic [3:0] REG_DSP_ADDR = 4'h2;
    localparam logic [3:0] REG_DSP_DATA = 4'h3;
    localparam logic [3:0] REG_PORT0    = 4'h4;
    localparam logic [3:0] REG_PORT1    = 4'h5;
    localparam logic [3:0] REG_PORT2    = 4'h6;
    localparam logic [3:0] REG_PORT3    = 4'h7;
    localparam logic [3:0] REG_AUX0     = 4'h8;
    localparam logic [3:0] REG_AUX1     = 4'h9;
    localparam logic [3:0] REG_TARGET0  = 4'hA;
    localparam logic [3:0] REG_COUNTER0 = 4'hD;
    localparam logic [3:0] REG_COUNTER1 = 4'hE;
    localparam logic [3:0] REG_COUNTER2 = 4'hF;

    localparam logic [11:0] IO_PAGE_HI  = 12'h00F;
    localparam logic [9:0]  ROM_BASE_HI = 10'h3FF;

    localparam int CTL_CLR_LO_BIT = 4;
    localparam int CTL_CLR_HI_BIT = 5;
    localparam int CTL_ROM_BIT    = 7;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  port_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] route;
        logic [6:0] dsp_index;
        logic       dsp_store;
        logic       ram_write;
        logic       rom_visible;
    } t_out_item;

    typedef struct packed {
        logic       tick;
        logic       ctl_wr;
        logic       on_val;
        logic       tgt_wr;
        logic [7:0] tgt_val;
        logic       cnt_clr;
    } t_tmr_ctl;

    function automatic logic [7:0] boot_rom(input logic [5:0] idx);
        logic [7:0] d;
        case (idx)
            6'd0:  d = 8'hcd; 6'd1:  d = 8'hef; 6'd2:  d = 8'hbd; 6'd3:  d = 8'he8;
            6'd4:  d = 8'h00; 6'd5:  d = 8'hc6; 6'd6:  d = 8'h1d; 6'd7:  d = 8'hd0;
            6'd8:  d = 8'hfc; 6'd9:  d = 8'h8f; 6'd10: d = 8'haa; 6'd11: d = 8'hf4;
            6'd12: d = 8'h8f; 6'd13: d = 8'hbb; 6'd14: d = 8'hf5; 6'd15: d = 8'h78;
            6'd16: d = 8'hcc; 6'd17: d = 8'hf4; 6'd18: d = 8'hd0; 6'd19: d = 8'hfb;
            6'd20: d = 8'h2f; 6'd21: d = 8'h19; 6'd22: d = 8'heb; 6'd23: d = 8'hf4;
            6'd24: d = 8'hd0; 6'd25: d = 8'hfc; 6'd26: d = 8'h7e; 6'd27: d = 8'hf4;
            6'd28: d = 8'hd0; 6'd29: d = 8'h0b; 6'd30: d = 8'he4; 6'd31: d = 8'hf5;
            6'd32: d = 8'hcb; 6'd33: d = 8'hf4; 6'd34: d = 8'hd7; 6'd35: d = 8'h00;
            6'd36: d = 8'hfc; 6'd37: d = 8'hd0; 6'd38: d = 8'hf3; 6'd39: d = 8'hab;
            6'd40: d = 8'h01; 6'd41: d = 8'h10; 6'd42: d = 8'hef; 6'd43: d = 8'h7e;
            6'd44: d = 8'hf4; 6'd45: d = 8'h10; 6'd46: d = 8'heb; 6'd47: d = 8'hba;
            6'd48: d = 8'hf6; 6'd49: d = 8'hda; 6'd50: d = 8'h00; 6'd51: d = 8'hba;
            6'd52: d = 8'hf4; 6'd53: d = 8'hc4; 6'd54: d = 8'hf4; 6'd55: d = 8'hdd;
            6'd56: d = 8'h5d; 6'd57: d = 8'hd0; 6'd58: d = 8'hdb; 6'd59: d = 8'h1f;
            6'd60: d = 8'h00; 6'd61: d = 8'h00; 6'd62: d = 8'hc0; 6'd63: d = 8'hff;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/sciot_timer.sv
// ----------------------------------------------------------------------------
// sciot_timer
// One timer: prescaler, 8-bit divider with target, 4-bit output counter.
// ----------------------------------------------------------------------------
module sciot_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_reload,
    input  sciot_pkg::t_tmr_ctl i_ctl,
    output logic [3:0]          o_counter
);

    logic [7:0] r_presc, n_presc;
    logic [7:0] r_div,   n_div;
    logic [7:0] r_tgt,   n_tgt;
    logic [3:0] r_cnt,   n_cnt;
    logic       r_on,    n_on;
    logic [7:0] div_inc;

    assign div_inc = r_div + 8'd1;

    always_comb begin
        n_presc = r_presc;
        n_div   = r_div;
        n_tgt   = r_tgt;
        n_cnt   = r_cnt;
        n_on    = r_on;
        if (i_ctl.tick) begin
            if (r_presc == 8'd0) begin
                n_presc = i_reload;
                if (r_on) begin
                    if (div_inc == r_tgt) begin
                        n_div = 8'd0;
                        n_cnt = r_cnt + 4'd1;
                    end else begin
                        n_div = div_inc;
                    end
                end
            end else begin
                n_presc = r_presc - 8'd1;
            end
        end
        if (i_ctl.ctl_wr) begin
            // restart divider and counter on an off-to-on enable
            if (!r_on && i_ctl.on_val) begin
                n_div = 8'd0;
                n_cnt = 4'd0;
            end
            n_on = i_ctl.on_val;
        end
        if (i_ctl.tgt_wr) begin
            n_tgt = i_ctl.tgt_val;
        end
        if (i_ctl.cnt_clr) begin
            n_cnt = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= 8'd0;
            r_div   <= 8'd0;
            r_tgt   <= 8'd0;
            r_cnt   <= 4'd0;
            r_on    <= 1'b0;
        end else begin
            r_presc <= n_presc;
            r_div   <= n_div;
            r_tgt   <= n_tgt;
            r_cnt   <= n_cnt;
            r_on    <= n_on;
        end
    end

    assign o_counter = r_cnt;

endmodule

### hw/rtl/sound_cpu_io_page_and_timers.sv
// ----------------------------------------------------------------------------
// sound_cpu_io_page_and_timers
// I/O register page, three timers and boot-ROM overlay of a sound CPU.
// ----------------------------------------------------------------------------
// Path: the accepted item is held in the input register, then decode and
// state update write the result register.
// Throughput: one item per cycle; while a result waits, input stays ready
// only until the input register fills.
// Reset (synchronous, active low): timers, latches and pointer clear,
// boot-ROM overlay on, both stages empty.
module sound_cpu_io_page_and_timers (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sciot_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sciot_pkg::t_out_item o_out_item
);

    sciot_pkg::t_in_item  r_in;
    logic                 r_in_valid;
    sciot_pkg::t_out_item r_out, n_out;
    logic                 r_out_valid;

    logic [7:0] r_in_latch  [sciot_pkg::NUM_IN_LATCH];
    logic [7:0] n_in_latch  [sciot_pkg::NUM_IN_LATCH];
    logic [7:0] r_out_latch [sciot_pkg::NUM_OUT_LATCH];
    logic [7:0] n_out_latch [sciot_pkg::NUM_OUT_LATCH];
    logic [7:0] r_dsp_ptr, n_dsp_ptr;
    logic       r_rom_on, n_rom_on;

    logic                adv_out;
    logic                proc;
    logic                is_io;
    logic                is_rom;
    logic [3:0]          lo;
    logic                cpu_rd, cpu_wr;
    logic [3:0]          tmr_cnt [sciot_pkg::NUM_TIMERS];
    sciot_pkg::t_tmr_ctl tmr_ctl [sciot_pkg::NUM_TIMERS];

    // output stage moves when empty or taken; input stage refills behind it
    assign adv_out    = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && adv_out;
    assign o_in_ready = !r_in_valid || adv_out;

    assign lo     = r_in.address[3:0];
    assign is_io  = (r_in.address[15:4] == sciot_pkg::IO_PAGE_HI);
    assign is_rom = (r_in.address[15:6] == sciot_pkg::ROM_BASE_HI);
    assign cpu_rd = proc && (r_in.action == sciot_pkg::ACT_CPU_RD);
    assign cpu_wr = proc && (r_in.action == sciot_pkg::ACT_CPU_WR);

    for (genvar t = 0; t < sciot_pkg::NUM_TIMERS; t++) begin : g_tmr
        always_comb begin
            tmr_ctl[t].tick    = proc && (r_in.action == sciot_pkg::ACT_TICK);
            tmr_ctl[t].ctl_wr  = cpu_wr && is_io && (lo == sciot_pkg::REG_CONTROL);
            tmr_ctl[t].on_val  = r_in.write_data[t];
            tmr_ctl[t].tgt_wr  = cpu_wr && is_io && (lo == sciot_pkg::REG_TARGET0 + 4'(t));
            tmr_ctl[t].tgt_val = r_in.write_data;
            tmr_ctl[t].cnt_clr = cpu_rd && is_io && (lo == sciot_pkg::REG_COUNTER0 + 4'(t));
        end

        sciot_timer u_timer (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_reload  ((t == sciot_pkg::NUM_TIMERS - 1) ? sciot_pkg::FAST_RELOAD
                                                         : sciot_pkg::SLOW_RELOAD),
            .i_ctl     (tmr_ctl[t]),
            .o_counter (tmr_cnt[t])
        );
    end

    always_comb begin
        n_in_latch  = r_in_latch;
        n_out_latch = r_out_latch;
        n_dsp_ptr   = r_dsp_ptr;
        n_rom_on    = r_rom_on;
        n_out       = '0;

        case (r_in.action)
            sciot_pkg::ACT_CPU_RD: begin
                if (is_io) begin
                    n_out.route = sciot_pkg::ROUTE_LOCAL;
                    case (lo)
                        sciot_pkg::REG_DSP_ADDR: n_out.read_data = r_dsp_ptr;
                        sciot_pkg::REG_DSP_DATA: begin
                            n_out.route     = sciot_pkg::ROUTE_DSP;
                            n_out.dsp_index = r_dsp_ptr[6:0];
                        end
                        sciot_pkg::REG_PORT0:    n_out.read_data = r_in_latch[0];
                        sciot_pkg::REG_PORT1:    n_out.read_data = r_in_latch[1];
                        sciot_pkg::REG_PORT2:    n_out.read_data = r_in_latch[2];
                        sciot_pkg::REG_PORT3:    n_out.read_data = r_in_latch[3];
                        sciot_pkg::REG_AUX0:     n_out.read_data = r_in_latch[4];
                        sciot_pkg::REG_AUX1:     n_out.read_data = r_in_latch[5];
                        sciot_pkg::REG_COUNTER0: n_out.read_data = {4'd0, tmr_cnt[0]};
                        sciot_pkg::REG_COUNTER1: n_out.read_data = {4'd0, tmr_cnt[1]};
                        sciot_pkg::REG_COUNTER2: n_out.read_data = {4'd0, tmr_cnt[2]};
                        default: n_out.read_data = 8'd0;
                    endcase
                end else if (r_rom_on && is_rom) begin
                    n_out.route     = sciot_pkg::ROUTE_ROM;
                    n_out.read_data = sciot_pkg::boot_rom(r_in.address[5:0]);
                end else begin
                    n_out.route = sciot_pkg::ROUTE_RAM;
                end
            end
            sciot_pkg::ACT_CPU_WR: begin
                n_out.ram_write = 1'b1;
                if (is_io) begin
                    n_out.route = sciot_pkg::ROUTE_LOCAL;
                    if (lo == sciot_pkg::REG_CONTROL) begin
                        if (r_in.write_data[sciot_pkg::CTL_CLR_LO_BIT]) begin
                            n_in_latch[0] = 8'd0;
                            n_in_latch[1] = 8'd0;
                        end
                        if (r_in.write_data[sciot_pkg::CTL_CLR_HI_BIT]) begin
                            n_in_latch[2] = 8'd0;
                            n_in_latch[3] = 8'd0;
                        end
                        n_rom_on = r_in.write_data[sciot_pkg::CTL_ROM_BIT];
                    end else if (lo == sciot_pkg::REG_DSP_ADDR) begin
                        n_dsp_ptr = r_in.write_data;
                    end else if (lo == sciot_pkg::REG_DSP_DATA) begin
                        // drop writes while the pointer is past the DSP register file
                        if (!r_dsp_ptr[7]) begin
                            n_out.dsp_index = r_dsp_ptr[6:0];
                            n_out.dsp_store = 1'b1;
                        end
                    end else if (lo >= sciot_pkg::REG_PORT0 && lo <= sciot_pkg::REG_PORT3) begin
                        n_out_latch[lo[1:0]] = r_in.write_data;
                    end else if (lo == sciot_pkg::REG_AUX0) begin
                        n_in_latch[4] = r_in.write_data;
                    end else if (lo == sciot_pkg::REG_AUX1) begin
                        n_in_latch[5] = r_in.write_data;
                    end
                end else begin
                    n_out.route = sciot_pkg::ROUTE_RAM;
                end
            end
            sciot_pkg::ACT_HOST_WR: begin
                n_in_latch[{1'b0, r_in.port_index}] = r_in.write_data;
            end
            sciot_pkg::ACT_HOST_RD: begin
                n_out.route     = sciot_pkg::ROUTE_LOCAL;
                n_out.read_data = r_out_latch[r_in.port_index];
            end
            default: begin
                n_out.route = sciot_pkg::ROUTE_NONE;
            end
        endcase

        n_out.rom_visible = n_rom_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dsp_ptr   <= 8'd0;
            r_rom_on    <= 1'b1;
            for (int k = 0; k < sciot_pkg::NUM_IN_LATCH; k++) begin
                r_in_latch[k] <= 8'd0;
            end
            for (int k = 0; k < sciot_pkg::NUM_OUT_LATCH; k++) begin
                r_out_latch[k] <= 8'd0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_dsp_ptr   <= n_dsp_ptr;
                r_rom_on    <= n_rom_on;
                r_in_latch  <= n_in_latch;
                r_out_latch <= n_out_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### bench/sound_cpu_io_page_and_timers_checker.sv
// ----------------------------------------------------------------------------
// sound_cpu_io_page_and_timers_checker
// Watches both item channels of the I/O page and keeps its own copy of the
// timers, latches, DSP pointer and ROM overlay. Each accepted access yields
// one predicted reply, and each reply taken from the block is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sound_cpu_io_page_and_timers_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  sciot_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  sciot_pkg::t_out_item i_out_item,
    output int                   o_pending,
    output int                   o_errors
);

    localparam int REPORT_LIMIT = 10;

    // Boot image, byte 0 in the top bits.
    localparam logic [511:0] BOOT_IMAGE = {
        128'hcdefbde800c61dd0fc8faaf48fbbf578,
        128'hccf4d0fb2f19ebf4d0fc7ef4d00be4f5,
        128'hcbf4d700fcd0f3ab0110ef7ef410ebba,
        128'hf6da00baf4c4f4dd5dd0db1f0000c0ff
    };

    logic [7:0] presc    [sciot_pkg::NUM_TIMERS];
    logic [7:0] div_cnt  [sciot_pkg::NUM_TIMERS];
    logic [7:0] div_tgt  [sciot_pkg::NUM_TIMERS];
    logic [3:0] tick_cnt [sciot_pkg::NUM_TIMERS];
    logic       tmr_en   [sciot_pkg::NUM_TIMERS];
    logic [7:0] in_lat   [sciot_pkg::NUM_IN_LATCH];
    logic [7:0] out_lat  [sciot_pkg::NUM_OUT_LATCH];
    logic [7:0] dsp_ptr;
    logic       rom_on;

    sciot_pkg::t_out_item due_replies [$];
    sciot_pkg::t_out_item want;
    sciot_pkg::t_out_item predicted;
    bit                   bad;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    // Apply one access to the page state and return the reply it produces.
    task automatic apply_access(input sciot_pkg::t_in_item it,
                                output sciot_pkg::t_out_item res);
        logic [3:0] off;
        bit         in_page;
        int         idx;
        res     = '0;
        off     = it.address[3:0];
        in_page = (it.address[15:4] == sciot_pkg::IO_PAGE_HI);
        case (it.action)
            sciot_pkg::ACT_TICK: begin
                for (int t = 0; t < sciot_pkg::NUM_TIMERS; t++) begin
                    if (presc[t] == 8'h00) begin
                        presc[t] = (t == 2) ? sciot_pkg::FAST_RELOAD : sciot_pkg::SLOW_RELOAD;
                        if (tmr_en[t]) begin
                            div_cnt[t] = div_cnt[t] + 8'h01;
                            // target zero matches only after the divider wraps
                            if (div_cnt[t] == div_tgt[t]) begin
                                div_cnt[t]  = 8'h00;
                                tick_cnt[t] = tick_cnt[t] + 4'h1;
                            end
                        end
                    end else begin
                        presc[t] = presc[t] - 8'h01;
                    end
                end
            end
            sciot_pkg::ACT_CPU_RD: begin
                if (in_page) begin
                    res.route = sciot_pkg::ROUTE_LOCAL;
                    if (off == sciot_pkg::REG_DSP_ADDR) begin
                        res.read_data = dsp_ptr;
                    end else if (off == sciot_pkg::REG_DSP_DATA) begin
                        res.route     = sciot_pkg::ROUTE_DSP;
                        res.dsp_index = dsp_ptr[6:0];
                    end else if (off >= sciot_pkg::REG_PORT0 && off <= sciot_pkg::REG_AUX1) begin
                        res.read_data = in_lat[off - sciot_pkg::REG_PORT0];
                    end else if (off >= sciot_pkg::REG_COUNTER0) begin
                        // read clears the counter
                        idx           = int'(off - sciot_pkg::REG_COUNTER0);
                        res.read_data = {4'h0, tick_cnt[idx]};
                        tick_cnt[idx] = 4'h0;
                    end
                end else if (rom_on && it.address[15:6] == sciot_pkg::ROM_BASE_HI) begin
                    res.route     = sciot_pkg::ROUTE_ROM;
                    res.read_data = BOOT_IMAGE[511 - 8 * int'(it.address[5:0]) -: 8];
                end else begin
                    res.route = sciot_pkg::ROUTE_RAM;
                end
            end
            sciot_pkg::ACT_CPU_WR: begin
                res.ram_write = 1'b1;
                if (!in_page) begin
                    res.route = sciot_pkg::ROUTE_RAM;
                end else begin
                    res.route = sciot_pkg::ROUTE_LOCAL;
                    if (off == sciot_pkg::REG_CONTROL) begin
                        for (int t = 0; t < sciot_pkg::NUM_TIMERS; t++) begin
                            // a timer switched on starts from a clean divider
                            if (!tmr_en[t] && it.write_data[t]) begin
                                div_cnt[t]  = 8'h00;
                                tick_cnt[t] = 4'h0;
                            end
                            tmr_en[t] = it.write_data[t];
                        end
                        if (it.write_data[sciot_pkg::CTL_CLR_LO_BIT]) begin
                            in_lat[0] = 8'h00;
                            in_lat[1] = 8'h00;
                        end
                        if (it.write_data[sciot_pkg::CTL_CLR_HI_BIT]) begin
                            in_lat[2] = 8'h00;
                            in_lat[3] = 8'h00;
                        end
                        rom_on = it.write_data[sciot_pkg::CTL_ROM_BIT];
                    end else if (off == sciot_pkg::REG_DSP_ADDR) begin
                        dsp_ptr = it.write_data;
                    end else if (off == sciot_pkg::REG_DSP_DATA) begin
                        // upper half of the pointer space is read-only
                        if (!dsp_ptr[7]) begin
                            res.dsp_index = dsp_ptr[6:0];
                            res.dsp_store = 1'b1;
                        end
                    end else if (off >= sciot_pkg::REG_PORT0 && off <= sciot_pkg::REG_PORT3) begin
                        out_lat[off - sciot_pkg::REG_PORT0] = it.write_data;
                    end else if (off == sciot_pkg::REG_AUX0 || off == sciot_pkg::REG_AUX1) begin
                        in_lat[off - sciot_pkg::REG_PORT0] = it.write_data;
                    end else if (off >= sciot_pkg::REG_TARGET0 &&
                                 off < sciot_pkg::REG_COUNTER0) begin
                        div_tgt[off - sciot_pkg::REG_TARGET0] = it.write_data;
                    end
                end
            end
            sciot_pkg::ACT_HOST_WR: begin
                in_lat[{1'b0, it.port_index}] = it.write_data;
            end
            sciot_pkg::ACT_HOST_RD: begin
                res.read_data = out_lat[it.port_index];
                res.route     = sciot_pkg::ROUTE_LOCAL;
            end
            default: begin
            end
        endcase
        res.rom_visible = rom_on;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < sciot_pkg::NUM_TIMERS; t++) begin
                presc[t]    = 8'h00;
                div_cnt[t]  = 8'h00;
                div_tgt[t]  = 8'h00;
                tick_cnt[t] = 4'h0;
                tmr_en[t]   = 1'b0;
            end
            for (int i = 0; i < sciot_pkg::NUM_IN_LATCH; i++) in_lat[i] = 8'h00;
            for (int i = 0; i < sciot_pkg::NUM_OUT_LATCH; i++) out_lat[i] = 8'h00;
            dsp_ptr = 8'h00;
            rom_on  = 1'b1;
            due_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_replies.size() == 0) begin
                    want = '0;
                    bad  = 1'b1;
                    if (o_errors < REPORT_LIMIT) begin
                        $display("%0t: reply with no access outstanding", $time);
                    end
                end else begin
                    want = due_replies.pop_front();
                    bad  = (i_out_item.read_data   !== want.read_data)   ||
                           (i_out_item.route       !== want.route)       ||
                           (i_out_item.dsp_index   !== want.dsp_index)   ||
                           (i_out_item.dsp_store   !== want.dsp_store)   ||
                           (i_out_item.ram_write   !== want.ram_write)   ||
                           (i_out_item.rom_visible !== want.rom_visible);
                end
                if (bad) begin
                    if (o_errors < REPORT_LIMIT) begin
                        $display("%0t: expected data %h route %0d dsp %h/%b ram %b rom %b",
                                 $time, want.read_data, want.route, want.dsp_index,
                                 want.dsp_store, want.ram_write, want.rom_visible);
                        $display("%0t: got      data %h route %0d dsp %h/%b ram %b rom %b",
                                 $time, i_out_item.read_data, i_out_item.route,
                                 i_out_item.dsp_index, i_out_item.dsp_store,
                                 i_out_item.ram_write, i_out_item.rom_visible);
                    end
                    o_errors = o_errors + 1;
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_access(i_in_item, predicted);
                due_replies.push_back(predicted);
            end
        end
        o_pending = due_replies.size();
    end

endmodule

### bench/sound_cpu_io_page_and_timers_tb.sv
// ----------------------------------------------------------------------------
// sound_cpu_io_page_and_timers_tb
// Drives ticks, CPU and host accesses into the I/O page: a directed pass over
// every route and a set of registers and corners, then random access sequences
// with random idling on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sound_cpu_io_page_and_timers_tb;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int MID_DRAIN     = 1000;
    localparam int QUIET_TAIL    = 1700;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 500000;

    // Action codes the block does not define
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    sciot_pkg::t_in_item  in_item;
    logic                 out_valid;
    logic                 out_ready;
    sciot_pkg::t_out_item out_item;
    int                   pending;
    int                   errors;

    int sent;
    int hold_cycles;
    bit tx_idle;
    bit rx_idle;
    bit drained_mid;

    sound_cpu_io_page_and_timers i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    sound_cpu_io_page_and_timers_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always #5 clk = ~clk;

    function automatic sciot_pkg::t_in_item bus_item(input logic [2:0] act,
                                                     input logic [15:0] adr,
                                                     input logic [7:0] wd,
                                                     input logic [1:0] pt);
        sciot_pkg::t_in_item it;
        it.action     = act;
        it.address    = adr;
        it.write_data = wd;
        it.port_index = pt;
        return it;
    endfunction

    function automatic logic [15:0] page_addr(input logic [3:0] r);
        return {sciot_pkg::IO_PAGE_HI, r};
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input sciot_pkg::t_in_item it);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (it.action <= sciot_pkg::ACT_HOST_RD) sent++;
    endtask

    // Hold off the sender until every outstanding reply is back.
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // Reply side stalls in bursts of random length while rx_idle is set.
    initial begin
        out_ready   = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                hold_cycles = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sound_cpu_io_page_and_timers_tb NOT OK");
        $finish;
    end

    initial begin
        int          k;
        logic [1:0]  p;
        logic [7:0]  v;
        logic [15:0] a;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        sent        = 0;
        drained_mid = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ports, aux latches, DSP pointer both halves, ROM and RAM,
        // target zero, control bits, counter read, unused action codes.
        send_item(bus_item(sciot_pkg::ACT_HOST_WR, 16'h0000, 8'hff, 2'd3));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_PORT3), 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_AUX0), 8'hff, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_AUX0), 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_PORT0), 8'ha5, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_HOST_RD, 16'hffff, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_ADDR),
                           8'h7f, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_DATA),
                           8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_DSP_DATA),
                           8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_ADDR),
                           8'h80, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_DATA),
                           8'hff, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_DSP_ADDR),
                           8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, {sciot_pkg::ROM_BASE_HI, 6'h00}, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, {sciot_pkg::ROM_BASE_HI, 6'h3f}, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, {sciot_pkg::ROM_BASE_HI, 6'h3f}, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, 16'h0000, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_TARGET0 + 4'd2),
                           8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_TARGET0),
                           8'h01, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_CONTROL),
                           8'h37, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_PORT3), 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, {sciot_pkg::ROM_BASE_HI, 6'h00}, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_TICK, 16'h0000, 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_COUNTER0),
                           8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_TEST), 8'h00, 2'd0));
        send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_CONTROL),
                           8'h80, 2'd0));
        send_item(bus_item(ACT_SPARE_HI, 16'hffff, 8'hff, 2'd3));
        send_item(bus_item(ACT_SPARE_LO, 16'h0000, 8'h00, 2'd0));
        drain_replies();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_idle = (sent < QUIET_TAIL) && ((sent / 250) % 3 != 2);
            rx_idle = (sent < QUIET_TAIL) && ((sent / 250) % 3 != 1);
            if (!drained_mid && sent >= MID_DRAIN) begin
                drain_replies();
                drained_mid = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // long runs let the 4-bit counters wrap
                    k = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
                    repeat (k) send_item(bus_item(sciot_pkg::ACT_TICK, 16'($urandom),
                                                  8'($urandom), 2'($urandom)));
                end
                3: begin
                    v = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) v[2:0] = 3'b111;
                    send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_CONTROL),
                                       v, 2'($urandom)));
                    v = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                    a = page_addr(sciot_pkg::REG_TARGET0 + 4'($urandom_range(0, 2)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_WR, a, v, 2'($urandom)));
                end
                4: begin
                    a = page_addr(sciot_pkg::REG_COUNTER0 + 4'($urandom_range(0, 2)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_RD, a, 8'($urandom), 2'($urandom)));
                end
                5: begin
                    send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_ADDR),
                                       8'($urandom), 2'($urandom)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_WR, page_addr(sciot_pkg::REG_DSP_DATA),
                                       8'($urandom), 2'($urandom)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_DSP_DATA),
                                       8'($urandom), 2'($urandom)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_RD, page_addr(sciot_pkg::REG_DSP_ADDR),
                                       8'($urandom), 2'($urandom)));
                end
                6: begin
                    p = 2'($urandom);
                    a = page_addr(sciot_pkg::REG_PORT0 + 4'(p));
                    send_item(bus_item(sciot_pkg::ACT_HOST_WR, 16'($urandom), 8'($urandom), p));
                    send_item(bus_item(sciot_pkg::ACT_CPU_RD, a, 8'($urandom), 2'($urandom)));
                    send_item(bus_item(sciot_pkg::ACT_CPU_WR, a, 8'($urandom), 2'($urandom)));
                    send_item(bus_item(sciot_pkg::ACT_HOST_RD, 16'($urandom), 8'($urandom), p));
                end
                7: begin
                    a = ($urandom_range(0, 1) == 0) ? {sciot_pkg::ROM_BASE_HI, 6'($urandom)}
                                                    : 16'($urandom);
                    send_item(bus_item(($urandom_range(0, 2) == 0) ? sciot_pkg::ACT_CPU_WR
                                                                   : sciot_pkg::ACT_CPU_RD,
                                       a, 8'($urandom), 2'($urandom)));
                end
                8: begin
                    send_item(bus_item(($urandom_range(0, 1) == 0) ? sciot_pkg::ACT_CPU_WR
                                                                   : sciot_pkg::ACT_CPU_RD,
                                       page_addr(4'($urandom)), 8'($urandom), 2'($urandom)));
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(bus_item(3'($urandom), 16'($urandom), 8'($urandom),
                                           2'($urandom)));
                    end
                end
            endcase
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("sound_cpu_io_page_and_timers_tb OK");
        end else begin
            $display("sound_cpu_io_page_and_timers_tb NOT OK");
        end
        $finish;
    end

endmodule

### sound_cpu_io_page_and_timers.f
hw/rtl/sciot_pkg.sv
hw/rtl/sciot_timer.sv
hw/rtl/sound_cpu_io_page_and_timers.sv
bench/sound_cpu_io_page_and_timers_checker.sv
bench/sound_cpu_io_page_and_timers_tb.sv
